FILE: rtl/core/idst_pkg.sv
// Package for the controller id and slot table.
// Holds table sizes, the request kind codes, the controller states and the
// command and status structs. It depends on nothing else.
`timescale 1ns / 1ps

package idst_pkg;

    localparam int ENTRIES    = 8;
    localparam int STAMP_BITS = 16;
    localparam int IDX_BITS   = $clog2(ENTRIES);

    localparam logic [7:0] FAILURE_CODE_RESET = 8'hFF;

    typedef enum logic [1:0] {
        KIND_DEV_BY_CTRL  = 2'd0,
        KIND_SLOT_BY_DEV  = 2'd1,
        KIND_RECORD_DEV   = 2'd2,
        KIND_ASSIGN_CTRL  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic out_busy;
    } status_t;

endpackage

FILE: rtl/core/idst_ctrl.sv
// Controller state machine for the controller id and slot table.
// Sequences capture, evaluation, the oldest-stamp scan and the commit.
// Depends on idst_pkg.
`timescale 1ns / 1ps

module idst_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  idst_pkg::status_t status,
    output idst_pkg::cmd_t    cmd
);

    idst_pkg::state_t state_reg;
    idst_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= idst_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            idst_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = idst_pkg::ST_EVAL;
                end
            end
            idst_pkg::ST_EVAL: begin
                if (status.need_scan) begin
                    state_next = idst_pkg::ST_SCAN;
                end else if (!status.out_busy) begin
                    state_next = idst_pkg::ST_IDLE;
                end
            end
            idst_pkg::ST_SCAN: begin
                if (status.scan_last) begin
                    state_next = idst_pkg::ST_COMMIT;
                end
            end
            idst_pkg::ST_COMMIT: begin
                if (!status.out_busy) begin
                    state_next = idst_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = idst_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd.load       = 1'b0;
        cmd.scan_start = 1'b0;
        cmd.scan_step  = 1'b0;
        cmd.commit     = 1'b0;
        case (state_reg)
            idst_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            idst_pkg::ST_EVAL: begin
                cmd.scan_start = status.need_scan;
                cmd.commit     = !status.need_scan && !status.out_busy;
            end
            idst_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            idst_pkg::ST_COMMIT: begin
                cmd.commit = !status.out_busy;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/core/idst_datapath.sv
// Datapath for the controller id and slot table.
// Holds the table, stamp counter, failure code, scan registers and the
// output register. Depends on idst_pkg.
`timescale 1ns / 1ps

module idst_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        s_kind,
    input  logic [7:0]        s_key_number,
    input  logic [7:0]        s_slot_value,
    output logic [7:0]        m_result_value,
    output logic              m_hit,
    output logic              m_valid,
    input  logic              m_ready,
    input  logic              cfg_valid,
    input  logic [7:0]        cfg_data,
    input  idst_pkg::cmd_t    cmd,
    output idst_pkg::status_t status
);

    localparam int N  = idst_pkg::ENTRIES;
    localparam int IB = idst_pkg::IDX_BITS;
    localparam int SB = idst_pkg::STAMP_BITS;

    logic [7:0]    ctrl_reg   [N];
    logic [7:0]    dev_reg    [N];
    logic [7:0]    slot_reg   [N];
    logic [SB-1:0] stamp_reg  [N];
    logic [N-1:0]  filled_reg;
    logic [SB-1:0] counter_reg;
    logic [7:0]    fail_reg;

    idst_pkg::kind_t req_kind_reg;
    logic [7:0]      req_key_reg;
    logic [7:0]      req_slot_reg;

    logic [IB-1:0] ptr_reg;
    logic [IB-1:0] best_idx_reg;
    logic [SB-1:0] best_reg;

    logic [7:0] out_value_reg;
    logic       out_hit_reg;
    logic       out_valid_reg;

    logic [N-1:0]  ctrl_match;
    logic [N-1:0]  dev_match;
    logic [N-1:0]  rec_match;
    logic          ctrl_found;
    logic          dev_found;
    logic          rec_found;
    logic          unf_found;
    logic [IB-1:0] ctrl_idx;
    logic [IB-1:0] dev_idx;
    logic [IB-1:0] rec_idx;
    logic [IB-1:0] unf_idx;
    logic [IB-1:0] wr_idx;
    logic [7:0]    value_next;
    logic          hit_next;

    always_comb begin
        ctrl_found = 1'b0;
        dev_found  = 1'b0;
        rec_found  = 1'b0;
        unf_found  = 1'b0;
        ctrl_idx   = '0;
        dev_idx    = '0;
        rec_idx    = '0;
        unf_idx    = '0;
        for (int i = N - 1; i >= 0; i--) begin
            ctrl_match[i] = (ctrl_reg[i] == req_key_reg);
            dev_match[i]  = (dev_reg[i] == req_key_reg);
            rec_match[i]  = dev_match[i] && !filled_reg[i];
            if (ctrl_match[i]) begin
                ctrl_found = 1'b1;
                ctrl_idx   = IB'(i);
            end
            if (dev_match[i]) begin
                dev_found = 1'b1;
                dev_idx   = IB'(i);
            end
            if (rec_match[i]) begin
                rec_found = 1'b1;
                rec_idx   = IB'(i);
            end
            if (!filled_reg[i]) begin
                unf_found = 1'b1;
                unf_idx   = IB'(i);
            end
        end
    end

    always_comb begin
        if (rec_found) begin
            wr_idx = rec_idx;
        end else if (unf_found) begin
            wr_idx = unf_idx;
        end else begin
            wr_idx = best_idx_reg;
        end
    end

    always_comb begin
        value_next = fail_reg;
        hit_next   = 1'b0;
        case (req_kind_reg)
            idst_pkg::KIND_DEV_BY_CTRL: begin
                if (ctrl_found) begin
                    value_next = dev_reg[ctrl_idx];
                    hit_next   = 1'b1;
                end
            end
            idst_pkg::KIND_SLOT_BY_DEV: begin
                if (dev_found) begin
                    value_next = slot_reg[dev_idx];
                    hit_next   = 1'b1;
                end
            end
            idst_pkg::KIND_RECORD_DEV: begin
                value_next = 8'(wr_idx);
                hit_next   = 1'b1;
            end
            idst_pkg::KIND_ASSIGN_CTRL: begin
                if (unf_found) begin
                    value_next = 8'(unf_idx);
                    hit_next   = 1'b1;
                end
            end
            default: begin
                hit_next = 1'b0;
            end
        endcase
    end

    assign status.need_scan = (req_kind_reg == idst_pkg::KIND_RECORD_DEV) &&
                              !rec_found && !unf_found;
    assign status.scan_last = (ptr_reg == IB'(N - 1));
    assign status.out_busy  = out_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                ctrl_reg[i]  <= '0;
                dev_reg[i]   <= '0;
                slot_reg[i]  <= '0;
                stamp_reg[i] <= '0;
            end
            filled_reg    <= '0;
            counter_reg   <= '0;
            fail_reg      <= idst_pkg::FAILURE_CODE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                fail_reg <= cfg_data;
            end
            if (cmd.commit) begin
                if (req_kind_reg == idst_pkg::KIND_RECORD_DEV) begin
                    dev_reg[wr_idx]    <= req_key_reg;
                    slot_reg[wr_idx]   <= req_slot_reg;
                    stamp_reg[wr_idx]  <= counter_reg;
                    filled_reg[wr_idx] <= 1'b1;
                    counter_reg        <= counter_reg + 1'b1;
                end else if ((req_kind_reg == idst_pkg::KIND_ASSIGN_CTRL) && unf_found) begin
                    ctrl_reg[unf_idx] <= req_key_reg;
                end
            end
            if (cmd.commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_kind_reg <= idst_pkg::kind_t'(s_kind);
            req_key_reg  <= s_key_number;
            req_slot_reg <= s_slot_value;
        end
        if (cmd.scan_start) begin
            best_reg     <= stamp_reg[0];
            best_idx_reg <= '0;
            ptr_reg      <= IB'(1);
        end else if (cmd.scan_step) begin
            if (stamp_reg[ptr_reg] < best_reg) begin
                best_reg     <= stamp_reg[ptr_reg];
                best_idx_reg <= ptr_reg;
            end
            ptr_reg <= ptr_reg + 1'b1;
        end
        if (cmd.commit) begin
            out_value_reg <= value_next;
            out_hit_reg   <= hit_next;
        end
    end

    assign m_result_value = out_value_reg;
    assign m_hit          = out_hit_reg;
    assign m_valid        = out_valid_reg;

endmodule

FILE: rtl/core/id_slot_table_oldest_replace.sv
// Top level of the controller id and slot table.
// Joins the controller state machine and the datapath.
// Depends on idst_pkg, idst_ctrl and idst_datapath.
`timescale 1ns / 1ps

// The s_ channel takes one request: s_kind, s_key_number and s_slot_value.
// Kind 0 looks up a device by controller number and kind 1 a slot by
// device number. Kind 2 records a device and slot, and kind 3 assigns a
// controller number to the first unfilled entry.
// The m_ channel returns one result per request: m_result_value and m_hit.
// The cfg channel writes the failure code returned on a miss and is always
// ready; the user must write it only while no request is in flight, as
// the block itself leaves this check to the user. A lookup, an assign, or
// a record that finds a free entry commits from the evaluate state and
// presents its result on m_valid from the output register. A record into
// a full table first scans the stamps one entry per cycle, then commits.
// A new request is taken only after the previous one has committed.
// A finished result waits in the output register while the next request is
// accepted and evaluated; that request only commits once the receiver takes
// the waiting result.
// A synchronous reset on aresetn clears the table, the stamp counter and
// the output valid flag, and sets the failure code to 255.
module id_slot_table_oldest_replace (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic [7:0] s_key_number,
    input  logic [7:0] s_slot_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_result_value,
    output logic       m_hit,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    idst_pkg::cmd_t    cmd;
    idst_pkg::status_t status;

    assign cfg_ready = 1'b1;

    idst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    idst_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_kind         (s_kind),
        .s_key_number   (s_key_number),
        .s_slot_value   (s_slot_value),
        .m_result_value (m_result_value),
        .m_hit          (m_hit),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the controller id and slot table.
// It predicts each reply from its own model of the table and compares every result
// field. It depends on idst_pkg and id_slot_table_oldest_replace.
`timescale 1ns / 1ps

module testbench;

    localparam int LIMIT_CYCLES = 4000000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int RANDOM_PHASES = 6;

    typedef struct packed {
        logic [7:0] value;
        logic       hit;
    } reply_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_kind = 2'd0;
    logic [7:0] s_key_number = 8'd0;
    logic [7:0] s_slot_value = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_result_value;
    logic       m_hit;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = 8'd0;

    logic [7:0]                      ctrl_num [idst_pkg::ENTRIES];
    logic [7:0]                      dev_num  [idst_pkg::ENTRIES];
    logic [7:0]                      slot_num [idst_pkg::ENTRIES];
    logic [idst_pkg::STAMP_BITS-1:0] stamp    [idst_pkg::ENTRIES];
    logic                            filled   [idst_pkg::ENTRIES];
    logic [idst_pkg::STAMP_BITS-1:0] stamp_count;
    logic [7:0]                      fail_code;

    reply_t pending_replies [$];

    int errors = 0;
    int cycle_count = 0;
    int request_count = 0;
    int replace_count = 0;
    int miss_count = 0;
    int setting_count = 0;
    int rx_hold = 0;
    int rx_gap = 0;
    bit rx_gaps_on = 1'b0;
    bit tx_gaps_on = 1'b0;

    id_slot_table_oldest_replace dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_key_number   (s_key_number),
        .s_slot_value   (s_slot_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_hit          (m_hit),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int pick_gap_len();
        if ($urandom_range(0, 99) < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 50);
    endfunction

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else if (rx_gap > 0) begin
            m_ready <= 1'b0;
            rx_gap = rx_gap - 1;
        end else if (rx_gaps_on && $urandom_range(0, 99) < 15) begin
            m_ready <= 1'b0;
            rx_gap = pick_gap_len() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected reply: result_value %0d, hit %0d", m_result_value, m_hit);
                errors++;
            end else begin
                want = pending_replies.pop_front();
                if (m_result_value !== want.value) begin
                    $error("result_value: expected %0d, actual %0d", want.value, m_result_value);
                    errors++;
                end
                if (m_hit !== want.hit) begin
                    $error("hit: expected %0d, actual %0d", want.hit, m_hit);
                    errors++;
                end
            end
        end
    end

    task automatic clear_table_model();
        int i;
        for (i = 0; i < idst_pkg::ENTRIES; i++) begin
            ctrl_num[i] = 8'd0;
            dev_num[i] = 8'd0;
            slot_num[i] = 8'd0;
            stamp[i] = '0;
            filled[i] = 1'b0;
        end
        stamp_count = '0;
        fail_code = idst_pkg::FAILURE_CODE_RESET;
    endtask

    function automatic int first_unfilled();
        int i;
        for (i = 0; i < idst_pkg::ENTRIES; i++) begin
            if (!filled[i]) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic reply_t apply_to_table(idst_pkg::kind_t kind, logic [7:0] key,
                                              logic [7:0] slot);
        reply_t r;
        int idx;
        int i;
        r.value = fail_code;
        r.hit = 1'b0;
        idx = -1;
        case (kind)
            idst_pkg::KIND_DEV_BY_CTRL: begin
                for (i = idst_pkg::ENTRIES - 1; i >= 0; i--) begin
                    if (ctrl_num[i] == key) begin
                        idx = i;
                    end
                end
                if (idx >= 0) begin
                    r.value = dev_num[idx];
                    r.hit = 1'b1;
                end
            end
            idst_pkg::KIND_SLOT_BY_DEV: begin
                for (i = idst_pkg::ENTRIES - 1; i >= 0; i--) begin
                    if (dev_num[i] == key) begin
                        idx = i;
                    end
                end
                if (idx >= 0) begin
                    r.value = slot_num[idx];
                    r.hit = 1'b1;
                end
            end
            idst_pkg::KIND_RECORD_DEV: begin
                for (i = idst_pkg::ENTRIES - 1; i >= 0; i--) begin
                    if (dev_num[i] == key && !filled[i]) begin
                        idx = i;
                    end
                end
                if (idx < 0) begin
                    idx = first_unfilled();
                end
                if (idx < 0) begin
                    idx = 0;
                    for (i = 1; i < idst_pkg::ENTRIES; i++) begin
                        if (stamp[i] < stamp[idx]) begin
                            idx = i;
                        end
                    end
                    replace_count++;
                end
                dev_num[idx] = key;
                slot_num[idx] = slot;
                stamp[idx] = stamp_count;
                filled[idx] = 1'b1;
                stamp_count = stamp_count + 1'b1;
                r.value = 8'(idx);
                r.hit = 1'b1;
            end
            default: begin
                idx = first_unfilled();
                if (idx >= 0) begin
                    ctrl_num[idx] = key;
                    r.value = 8'(idx);
                    r.hit = 1'b1;
                end
            end
        endcase
        if (!r.hit) begin
            miss_count++;
        end
        return r;
    endfunction

    task automatic send_request(input idst_pkg::kind_t kind, input logic [7:0] key,
                                input logic [7:0] slot);
        int gap;
        s_valid <= 1'b1;
        s_kind <= kind;
        s_key_number <= key;
        s_slot_value <= slot;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        pending_replies.push_back(apply_to_table(kind, key, slot));
        request_count++;
        if (tx_gaps_on && $urandom_range(0, 99) < 40) begin
            gap = pick_gap_len();
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random_request();
        int r;
        int q;
        idst_pkg::kind_t kind;
        logic [7:0] key;
        r = $urandom_range(0, 99);
        q = $urandom_range(0, 9);
        if (r < 30) begin
            kind = idst_pkg::KIND_DEV_BY_CTRL;
        end else if (r < 55) begin
            kind = idst_pkg::KIND_SLOT_BY_DEV;
        end else if (r < 85) begin
            kind = idst_pkg::KIND_RECORD_DEV;
        end else begin
            kind = idst_pkg::KIND_ASSIGN_CTRL;
        end
        if (q < 7) begin
            key = 8'($urandom_range(0, 11));
        end else if (q < 9) begin
            key = 8'($urandom());
        end else begin
            key = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        send_request(kind, key, 8'($urandom()));
    endtask

    task automatic wait_for_replies();
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) begin
            @(posedge aclk);
        end
        repeat (idst_pkg::ENTRIES + 8) @(posedge aclk);
    endtask

    task automatic write_failure_code(input logic [7:0] code);
        wait_for_replies();
        cfg_valid <= 1'b1;
        cfg_data <= code;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        fail_code = code;
        setting_count++;
    endtask

    task automatic test_reset_contents();
        send_request(idst_pkg::KIND_DEV_BY_CTRL, 8'h00, 8'h00);
        send_request(idst_pkg::KIND_DEV_BY_CTRL, 8'hFF, 8'hFF);
        send_request(idst_pkg::KIND_SLOT_BY_DEV, 8'h00, 8'h00);
        send_request(idst_pkg::KIND_SLOT_BY_DEV, 8'hFF, 8'h00);
    endtask

    task automatic test_fill_and_replace();
        int i;
        write_failure_code(8'h00);
        send_request(idst_pkg::KIND_ASSIGN_CTRL, 8'h07, 8'hFF);
        send_request(idst_pkg::KIND_ASSIGN_CTRL, 8'h09, 8'h00);
        send_request(idst_pkg::KIND_DEV_BY_CTRL, 8'h09, 8'h00);
        send_request(idst_pkg::KIND_RECORD_DEV, 8'h00, 8'hFF);
        send_request(idst_pkg::KIND_RECORD_DEV, 8'hFF, 8'h00);
        for (i = 3; i <= 8; i++) begin
            send_request(idst_pkg::KIND_RECORD_DEV, 8'(i), 8'(i * 17));
        end
        send_request(idst_pkg::KIND_ASSIGN_CTRL, 8'h05, 8'h00);
        send_request(idst_pkg::KIND_RECORD_DEV, 8'h64, 8'hAA);
        send_request(idst_pkg::KIND_DEV_BY_CTRL, 8'h09, 8'h00);
        send_request(idst_pkg::KIND_SLOT_BY_DEV, 8'h64, 8'h00);
        send_request(idst_pkg::KIND_SLOT_BY_DEV, 8'h00, 8'h00);
        send_request(idst_pkg::KIND_DEV_BY_CTRL, 8'h00, 8'h00);
        send_request(idst_pkg::KIND_RECORD_DEV, 8'hFF, 8'h55);
        send_request(idst_pkg::KIND_SLOT_BY_DEV, 8'hFF, 8'h00);
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        logic [7:0] code;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: code = 8'hFF;
                2: code = 8'h00;
                4: code = 8'h01;
                default: code = 8'($urandom());
            endcase
            write_failure_code(code);
            rx_gaps_on = (phase % 3) != 1;
            tx_gaps_on = (phase % 3) != 1;
            for (n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) begin
                send_random_request();
            end
        end
        wait_for_replies();
    endtask

    task automatic test_backpressure();
        int n;
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        rx_hold = 300;
        for (n = 0; n < 30; n++) begin
            send_random_request();
        end
        wait_for_replies();
        for (n = 0; n < 10; n++) begin
            send_random_request();
        end
        wait_for_replies();
    endtask

    initial begin
        clear_table_model();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_contents();
        test_fill_and_replace();
        test_random_traffic();
        test_backpressure();
        wait_for_replies();
        repeat (20) @(posedge aclk);
        $display("Covered %0d requests with %0d full-table replacements and %0d misses,",
                 request_count, replace_count, miss_count);
        $display("across %0d failure code settings and a long receiver stall.",
                 setting_count);
        if (errors == 0 && pending_replies.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
